### rtl/core/mnpt_pkg.sv
// ============================================================================
// MIDI note playback tracker package
// Shared request codes, internal word formats and default sizes.
// ============================================================================
package mnpt_pkg;

    // Field widths of the external words.
    localparam int REQ_W  = 3;
    localparam int CHAN_W = 4;
    localparam int KEY_W  = 7;
    localparam int VEL_W  = 7;
    localparam int TICK_W = 32;

    // Default channel count and queue depths.
    localparam int CHANNELS_DEF  = 16;
    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    // Request codes on the input word.
    localparam logic [REQ_W-1:0] REQ_TICK_BEGIN = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK_END   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PLAY       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STOP       = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SEEK       = 3'd6;

    // Command codes passed from the front end to the back end.
    localparam logic [1:0] CMD_SCAN     = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

    // Message kinds on the result word.
    localparam logic MSG_NOTE_OFF = 1'b0;
    localparam logic MSG_NOTE_ON  = 1'b1;

    // Command word: tick holds the scan tick or the end tick of a new note.
    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAN_W-1:0] channel;
        logic [KEY_W-1:0]  key;
        logic [VEL_W-1:0]  vel;
        logic [TICK_W-1:0] tick;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] channel;
        logic [KEY_W-1:0]  key;
        logic [VEL_W-1:0]  vel;
        logic              last;
    } msg_t;

endpackage

### rtl/core/mnpt_fifo.sv
// ============================================================================
// MIDI note playback tracker queue
// Small register queue with push/full and pop/empty on its two sides.
// ============================================================================
module mnpt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; a slot is read only after it was written.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/core/mnpt_front.sv
// ============================================================================
// MIDI note playback tracker front end
// Accepts requests, runs the transport and queues channel commands.
// ============================================================================
module mnpt_front #(
    parameter int CHANNELS = mnpt_pkg::CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mnpt_pkg::REQ_W-1:0]  req_type,
    input  logic [mnpt_pkg::CHAN_W-1:0] channel,
    input  logic [mnpt_pkg::KEY_W-1:0]  note_key,
    input  logic [mnpt_pkg::VEL_W-1:0]  velocity,
    input  logic [mnpt_pkg::TICK_W-1:0] note_start,
    input  logic [mnpt_pkg::TICK_W-1:0] note_length,
    input  logic [mnpt_pkg::TICK_W-1:0] seek_tick,
    output logic                        cmd_push,
    output mnpt_pkg::cmd_t              cmd_data,
    input  logic                        cmd_full
);

    logic                        running_reg, running_next;
    logic [mnpt_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic                        accept;
    logic                        chan_ok;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    assign chan_ok = (32'(channel) < CHANNELS);

    // Request decode: transport requests finish here, note work is queued.
    always_comb
    begin
        running_next     = running_reg;
        tick_next        = tick_reg;
        cmd_push         = 1'b0;
        cmd_data.kind    = mnpt_pkg::CMD_SCAN;
        cmd_data.channel = channel;
        cmd_data.key     = note_key;
        cmd_data.vel     = velocity;
        cmd_data.tick    = tick_reg;
        if (accept)
        begin
            case (req_type)
                mnpt_pkg::REQ_TICK_BEGIN:
                begin
                    cmd_push = running_reg;
                end
                mnpt_pkg::REQ_NOTE_ON:
                begin
                    cmd_push      = running_reg && chan_ok;
                    cmd_data.kind = mnpt_pkg::CMD_NOTE_ON;
                    cmd_data.tick = note_start + note_length;
                end
                mnpt_pkg::REQ_NOTE_OFF:
                begin
                    cmd_push      = running_reg && chan_ok;
                    cmd_data.kind = mnpt_pkg::CMD_NOTE_OFF;
                end
                mnpt_pkg::REQ_TICK_END:
                begin
                    if (running_reg)
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
                mnpt_pkg::REQ_PLAY:
                begin
                    tick_next    = '0;
                    running_next = 1'b1;
                end
                mnpt_pkg::REQ_STOP:
                begin
                    running_next = 1'b0;
                end
                mnpt_pkg::REQ_SEEK:
                begin
                    tick_next = seek_tick;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            tick_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            tick_reg    <= tick_next;
        end
    end

endmodule

### rtl/core/mnpt_back.sv
// ============================================================================
// MIDI note playback tracker back end
// Holds the per-channel note state and turns commands into note messages.
// ============================================================================
module mnpt_back #(
    parameter int CHANNELS = mnpt_pkg::CHANNELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  mnpt_pkg::cmd_t cmd_data,
    output logic           cmd_pop,
    output logic           out_push,
    output mnpt_pkg::msg_t out_data,
    input  logic           out_full
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_FLUSH    = 3'd2;
    localparam logic [2:0] ST_OLD_OFF  = 3'd3;
    localparam logic [2:0] ST_NOTE_ON  = 3'd4;
    localparam logic [2:0] ST_NOTE_OFF = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [CH_W-1:0]             idx_reg, idx_next;
    mnpt_pkg::cmd_t              cur_reg, cur_next;
    logic                        pend_valid_reg, pend_valid_next;
    mnpt_pkg::msg_t              pend_msg_reg, pend_msg_next;

    logic                        active_reg [CHANNELS];
    logic [mnpt_pkg::KEY_W-1:0]  key_reg [CHANNELS];
    logic [mnpt_pkg::TICK_W-1:0] end_reg [CHANNELS];

    logic [CH_W-1:0]             cur_idx;
    logic [CH_W-1:0]             rd_idx;
    logic                        rd_active;
    logic [mnpt_pkg::KEY_W-1:0]  rd_key;
    logic                        hit;
    logic                        act_wr_en;
    logic                        act_wr_val;
    logic                        note_wr_en;

    // One read port into the channel state: scan index or command channel.
    assign cur_idx   = cur_reg.channel[CH_W-1:0];
    assign rd_idx    = (state_reg == ST_SCAN) ? idx_reg : cur_idx;
    assign rd_active = active_reg[rd_idx];
    assign rd_key    = key_reg[rd_idx];
    assign hit       = rd_active && (cur_reg.tick >= end_reg[rd_idx]);

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        pend_valid_next  = pend_valid_reg;
        pend_msg_next    = pend_msg_reg;
        cmd_pop          = 1'b0;
        out_push         = 1'b0;
        out_data.kind    = mnpt_pkg::MSG_NOTE_OFF;
        out_data.channel = cur_reg.channel;
        out_data.key     = cur_reg.key;
        out_data.vel     = '0;
        out_data.last    = 1'b1;
        act_wr_en        = 1'b0;
        act_wr_val       = 1'b0;
        note_wr_en       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd_data;
                    idx_next = '0;
                    case (cmd_data.kind)
                        mnpt_pkg::CMD_SCAN:     state_next = ST_SCAN;
                        mnpt_pkg::CMD_NOTE_ON:  state_next = ST_OLD_OFF;
                        mnpt_pkg::CMD_NOTE_OFF: state_next = ST_NOTE_OFF;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // A found note waits in the pending slot until the next one
                // shows it was not the final message.
                if (!(hit && pend_valid_reg && out_full))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_push      = 1'b1;
                            out_data      = pend_msg_reg;
                            out_data.last = 1'b0;
                        end
                        pend_valid_next       = 1'b1;
                        pend_msg_next.kind    = mnpt_pkg::MSG_NOTE_OFF;
                        pend_msg_next.channel = mnpt_pkg::CHAN_W'(idx_reg);
                        pend_msg_next.key     = rd_key;
                        pend_msg_next.vel     = '0;
                        pend_msg_next.last    = 1'b0;
                        act_wr_en             = 1'b1;
                    end
                    if (idx_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_full)
                begin
                    out_push        = 1'b1;
                    out_data        = pend_msg_reg;
                    out_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_OLD_OFF:
            begin
                // The channel's previous note is released first.
                if (!rd_active)
                begin
                    state_next = ST_NOTE_ON;
                end
                else if (!out_full)
                begin
                    out_push      = 1'b1;
                    out_data.key  = rd_key;
                    out_data.last = 1'b0;
                    state_next    = ST_NOTE_ON;
                end
            end
            ST_NOTE_ON:
            begin
                if (!out_full)
                begin
                    out_push      = 1'b1;
                    out_data.kind = mnpt_pkg::MSG_NOTE_ON;
                    out_data.vel  = cur_reg.vel;
                    act_wr_en     = 1'b1;
                    act_wr_val    = 1'b1;
                    note_wr_en    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NOTE_OFF:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    act_wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Command and pending message payload.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_msg_reg <= pend_msg_next;
    end

    // Active flags reset to idle; key and end tick are read only when active.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                active_reg[i] <= 1'b0;
            end
        end
        else if (act_wr_en)
        begin
            active_reg[rd_idx] <= act_wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (note_wr_en)
        begin
            key_reg[cur_idx] <= cur_reg.key;
            end_reg[cur_idx] <= cur_reg.tick;
        end
    end

    // A message is never pushed into a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result pushed while queue full");

    // Commands are taken only when idle and one is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE) && !cmd_empty)
        else $error("command popped outside idle");

    // No scan result may be left pending once the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending message left behind");

    // A started note leaves its channel active.
    assert property (@(posedge clk) disable iff (!rst_n)
        note_wr_en |=> active_reg[$past(cur_idx)])
        else $error("note on did not mark channel active");

endmodule

### rtl/core/midi_note_playback_tracker.sv
// ============================================================================
// MIDI note playback tracker
// Transport-driven tracker of one sounding note per channel.
// ============================================================================
// Requests enter through a queue-style port (push/full) and note messages
// leave through another (empty/pop). The front end takes one request per
// cycle while the command queue has room: play, stop, seek and tick_end
// finish there at once, while tick_begin, note_on and note_off are queued
// as commands while running (up to CMD_DEPTH deep) for the back end, which
// owns the per-channel state and has one read port into it. A tick_begin
// makes the back end compare one channel per cycle, unless a found note
// waits for room in the result queue, then send the final message. A note_on
// first releases the channel's old note, if any. Every message needs a free
// slot in the OUT_DEPTH-deep result queue; a request's final message carries last = 1.
module midi_note_playback_tracker #(
    parameter int CHANNELS  = mnpt_pkg::CHANNELS_DEF,
    parameter int CMD_DEPTH = mnpt_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = mnpt_pkg::OUT_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mnpt_pkg::REQ_W-1:0]  req_type,
    input  logic [mnpt_pkg::CHAN_W-1:0] channel,
    input  logic [mnpt_pkg::KEY_W-1:0]  note_key,
    input  logic [mnpt_pkg::VEL_W-1:0]  velocity,
    input  logic [mnpt_pkg::TICK_W-1:0] note_start,
    input  logic [mnpt_pkg::TICK_W-1:0] note_length,
    input  logic [mnpt_pkg::TICK_W-1:0] seek_tick,
    output logic                        empty,
    input  logic                        pop,
    output logic                        msg_kind,
    output logic [mnpt_pkg::CHAN_W-1:0] out_channel,
    output logic [mnpt_pkg::KEY_W-1:0]  out_key,
    output logic [mnpt_pkg::VEL_W-1:0]  out_velocity,
    output logic                        last
);

    localparam int CMD_W = $bits(mnpt_pkg::cmd_t);
    localparam int MSG_W = $bits(mnpt_pkg::msg_t);

    logic             cmd_push;
    mnpt_pkg::cmd_t   cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_out_bits;
    logic             cmd_empty;
    logic             out_push;
    mnpt_pkg::msg_t   msg_in;
    logic             out_full;
    logic [MSG_W-1:0] msg_out_bits;
    mnpt_pkg::msg_t   msg_out;

    // Request decode and transport.
    mnpt_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .channel     (channel),
        .note_key    (note_key),
        .velocity    (velocity),
        .note_start  (note_start),
        .note_length (note_length),
        .seek_tick   (seek_tick),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .cmd_full    (cmd_full)
    );

    // Command queue between the two halves.
    mnpt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out_bits),
        .empty (cmd_empty)
    );

    // Channel state and message generation.
    mnpt_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (mnpt_pkg::cmd_t'(cmd_out_bits)),
        .cmd_pop   (cmd_pop),
        .out_push  (out_push),
        .out_data  (msg_in),
        .out_full  (out_full)
    );

    // Result queue toward the consumer.
    mnpt_fifo #(
        .WIDTH (MSG_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (msg_in),
        .full  (out_full),
        .pop   (pop),
        .dout  (msg_out_bits),
        .empty (empty)
    );

    assign msg_out      = mnpt_pkg::msg_t'(msg_out_bits);
    assign msg_kind     = msg_out.kind;
    assign out_channel  = msg_out.channel;
    assign out_key      = msg_out.key;
    assign out_velocity = msg_out.vel;
    assign last         = msg_out.last;

endmodule

### verif/midi_note_playback_tracker_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// MIDI note playback tracker testbench
// Drives request words through the push/full port and pops note message
// words through the empty/pop port. A scoreboard keeps its own copy of the
// transport and per-channel note state, predicts the messages of every
// accepted request word and checks each popped word field by field.
// ============================================================================

// One request word as it goes onto the input ports.
typedef struct {
    logic [mnpt_pkg::REQ_W-1:0]  req;
    logic [mnpt_pkg::CHAN_W-1:0] chan;
    logic [mnpt_pkg::KEY_W-1:0]  key;
    logic [mnpt_pkg::VEL_W-1:0]  vel;
    logic [mnpt_pkg::TICK_W-1:0] start;
    logic [mnpt_pkg::TICK_W-1:0] length;
    logic [mnpt_pkg::TICK_W-1:0] seek;
} request_t;

class midi_msg_scoreboard;
    bit                          running;
    logic [mnpt_pkg::TICK_W-1:0] tick;
    bit                          sounding [mnpt_pkg::CHANNELS_DEF];
    logic [mnpt_pkg::KEY_W-1:0]  held_key [mnpt_pkg::CHANNELS_DEF];
    logic [mnpt_pkg::TICK_W-1:0] end_tick [mnpt_pkg::CHANNELS_DEF];
    mnpt_pkg::msg_t              due_msgs [$];
    int                          mismatches;

    function new();
        running    = 1'b0;
        tick       = '0;
        mismatches = 0;
        for (int ch = 0; ch < mnpt_pkg::CHANNELS_DEF; ch++)
        begin
            sounding[ch] = 1'b0;
            held_key[ch] = '0;
            end_tick[ch] = '0;
        end
    endfunction

    function void add_msg(logic kind, int ch, logic [mnpt_pkg::KEY_W-1:0] key,
                          logic [mnpt_pkg::VEL_W-1:0] vel);
        mnpt_pkg::msg_t m;
        m.kind    = kind;
        m.channel = ch[mnpt_pkg::CHAN_W-1:0];
        m.key     = key;
        m.vel     = vel;
        m.last    = 1'b0;
        due_msgs  = {due_msgs, m};
    endfunction

    // Update the tracker state for one accepted request and queue its messages.
    function void note_request(request_t r);
        int             first;
        mnpt_pkg::msg_t m;
        first = due_msgs.size();
        case (r.req)
            mnpt_pkg::REQ_TICK_BEGIN:
                if (running)
                begin
                    // Channels are scanned in ascending order.
                    for (int ch = 0; ch < mnpt_pkg::CHANNELS_DEF; ch++)
                    begin
                        if (sounding[ch] && tick >= end_tick[ch])
                        begin
                            add_msg(mnpt_pkg::MSG_NOTE_OFF, ch, held_key[ch], '0);
                            sounding[ch] = 1'b0;
                        end
                    end
                end
            mnpt_pkg::REQ_NOTE_ON:
                if (running && r.chan < mnpt_pkg::CHANNELS_DEF)
                begin
                    // A note still sounding on the channel is cut first.
                    if (sounding[r.chan])
                        add_msg(mnpt_pkg::MSG_NOTE_OFF, r.chan, held_key[r.chan], '0);
                    add_msg(mnpt_pkg::MSG_NOTE_ON, r.chan, r.key, r.vel);
                    sounding[r.chan] = 1'b1;
                    held_key[r.chan] = r.key;
                    end_tick[r.chan] = r.start + r.length;
                end
            mnpt_pkg::REQ_NOTE_OFF:
                if (running && r.chan < mnpt_pkg::CHANNELS_DEF)
                begin
                    add_msg(mnpt_pkg::MSG_NOTE_OFF, r.chan, r.key, '0);
                    sounding[r.chan] = 1'b0;
                end
            mnpt_pkg::REQ_TICK_END:
                if (running)
                    tick = tick + 1'b1;
            mnpt_pkg::REQ_PLAY:
            begin
                tick    = '0;
                running = 1'b1;
            end
            mnpt_pkg::REQ_STOP:
                running = 1'b0;
            mnpt_pkg::REQ_SEEK:
                tick = r.seek;
            default:
                ;
        endcase
        // The final message of the request carries the last flag.
        if (due_msgs.size() > first)
        begin
            m = due_msgs[due_msgs.size() - 1];
            m.last = 1'b1;
            due_msgs[due_msgs.size() - 1] = m;
        end
    endfunction

    task report(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // Compare one popped message word with the oldest prediction.
    task check_message(mnpt_pkg::msg_t got);
        mnpt_pkg::msg_t want;
        if (due_msgs.size() == 0)
        begin
            report($sformatf("unexpected message kind=%0d ch=%0d key=%0d vel=%0d last=%0d",
                             got.kind, got.channel, got.key, got.vel, got.last));
            return;
        end
        want = due_msgs.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("msg_kind %0d, want %0d", got.kind, want.kind));
        if (got.channel !== want.channel)
            report($sformatf("out_channel %0d, want %0d", got.channel, want.channel));
        if (got.key !== want.key)
            report($sformatf("out_key %0d, want %0d", got.key, want.key));
        if (got.vel !== want.vel)
            report($sformatf("out_velocity %0d, want %0d", got.vel, want.vel));
        if (got.last !== want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask

    function int pending();
        return due_msgs.size();
    endfunction
endclass

module midi_note_playback_tracker_tb;

    localparam logic [mnpt_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int TOTAL_ITEMS = 425;
    localparam int HOLD_CYCLES = 400;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        push         = 1'b0;
    logic                        pop          = 1'b0;
    logic [mnpt_pkg::REQ_W-1:0]  req_type     = '0;
    logic [mnpt_pkg::CHAN_W-1:0] channel      = '0;
    logic [mnpt_pkg::KEY_W-1:0]  note_key     = '0;
    logic [mnpt_pkg::VEL_W-1:0]  velocity     = '0;
    logic [mnpt_pkg::TICK_W-1:0] note_start   = '0;
    logic [mnpt_pkg::TICK_W-1:0] note_length  = '0;
    logic [mnpt_pkg::TICK_W-1:0] seek_tick    = '0;
    logic                        full;
    logic                        empty;
    logic                        msg_kind;
    logic [mnpt_pkg::CHAN_W-1:0] out_channel;
    logic [mnpt_pkg::KEY_W-1:0]  out_key;
    logic [mnpt_pkg::VEL_W-1:0]  out_velocity;
    logic                        last;

    midi_msg_scoreboard msg_board;
    bit                 hold_off_req = 1'b0;
    bit                 burst        = 1'b0;
    int                 items_sent   = 0;

    midi_note_playback_tracker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .channel      (channel),
        .note_key     (note_key),
        .velocity     (velocity),
        .note_start   (note_start),
        .note_length  (note_length),
        .seek_tick    (seek_tick),
        .empty        (empty),
        .pop          (pop),
        .msg_kind     (msg_kind),
        .out_channel  (out_channel),
        .out_key      (out_key),
        .out_velocity (out_velocity),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one request word and wait until the block takes it.
    task automatic send_request(request_t r);
        int gap;
        gap = (burst || items_sent % 100 < 15) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        req_type    <= r.req;
        channel     <= r.chan;
        note_key    <= r.key;
        velocity    <= r.vel;
        note_start  <= r.start;
        note_length <= r.length;
        seek_tick   <= r.seek;
        @(posedge clk);
        while (full)
            @(posedge clk);
        msg_board.note_request(r);
        items_sent++;
    endtask

    task automatic send_fields(logic [mnpt_pkg::REQ_W-1:0] req, int ch, int key, int vel,
                               logic [mnpt_pkg::TICK_W-1:0] start,
                               logic [mnpt_pkg::TICK_W-1:0] length,
                               logic [mnpt_pkg::TICK_W-1:0] seek);
        request_t r;
        r.req    = req;
        r.chan   = mnpt_pkg::CHAN_W'(ch);
        r.key    = mnpt_pkg::KEY_W'(key);
        r.vel    = mnpt_pkg::VEL_W'(vel);
        r.start  = start;
        r.length = length;
        r.seek   = seek;
        send_request(r);
    endtask

    // A request word of the given kind with every other field random.
    function automatic request_t random_request(logic [mnpt_pkg::REQ_W-1:0] req);
        request_t r;
        r.req    = req;
        r.chan   = mnpt_pkg::CHAN_W'($urandom_range(0, 15));
        r.key    = mnpt_pkg::KEY_W'($urandom_range(0, 127));
        r.vel    = mnpt_pkg::VEL_W'($urandom_range(0, 127));
        r.start  = $urandom();
        r.length = $urandom();
        r.seek   = $urandom();
        return r;
    endfunction

    // Request words: directed cases first, then random transport traffic.
    initial
    begin : stimulus
        request_t r;
        int       pick;
        int       holds;
        holds = 0;
        msg_board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Nothing but play, stop and seek acts while stopped.
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_NOTE_ON, 5, 60, 100, 0, 10, 0);
        send_fields(mnpt_pkg::REQ_NOTE_OFF, 5, 60, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_END, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_SEEK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_fields(mnpt_pkg::REQ_STOP, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_UNUSED, 15, 127, 127, '1, '1, '1);
        send_fields(mnpt_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 0);

        // Field extremes, a replaced note and an end tick that wraps.
        send_fields(mnpt_pkg::REQ_NOTE_ON, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_NOTE_ON, 15, 127, 127, 32'hFFFF_FFFF, 2, 0);
        send_fields(mnpt_pkg::REQ_NOTE_ON, 0, 127, 1, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_END, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_NOTE_OFF, 7, 64, 0, 0, 0, 0);

        // The tick counter at the top of its range and its wrap to zero.
        send_fields(mnpt_pkg::REQ_SEEK, 0, 0, 0, 0, 0, 32'hFFFF_FFFE);
        send_fields(mnpt_pkg::REQ_NOTE_ON, 3, 33, 77, 32'hFFFF_FFF0, 32'h0000_000F, 0);
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_END, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_END, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_UNUSED, 0, 0, 0, 0, 0, 0);

        // Stop keeps the note, play restarts the tick with the note kept.
        send_fields(mnpt_pkg::REQ_NOTE_ON, 9, 50, 90, 0, 100, 0);
        send_fields(mnpt_pkg::REQ_STOP, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_TICK_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 0);
        send_fields(mnpt_pkg::REQ_NOTE_OFF, 9, 50, 0, 0, 0, 0);

        // Random traffic, mostly notes that start and end while running.
        while (items_sent < TOTAL_ITEMS)
        begin
            if (holds < 2 && items_sent >= 150 * (holds + 1))
            begin
                hold_off_req = 1'b1;
                holds++;
            end
            if (!msg_board.running && $urandom_range(0, 3) != 0)
                send_request(random_request(mnpt_pkg::REQ_PLAY));
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r = random_request(mnpt_pkg::REQ_NOTE_ON);
                if ($urandom_range(0, 7) != 0)
                begin
                    r.start  = msg_board.tick + $urandom_range(0, 3);
                    r.length = $urandom_range(0, 6);
                end
                send_request(r);
            end
            else if (pick < 58)
            begin
                send_request(random_request(mnpt_pkg::REQ_TICK_BEGIN));
                send_request(random_request(mnpt_pkg::REQ_TICK_END));
            end
            else if (pick < 66)
            begin
                r = random_request(mnpt_pkg::REQ_NOTE_OFF);
                if ($urandom_range(0, 1) != 0)
                    r.key = msg_board.held_key[r.chan];
                send_request(r);
            end
            else if (pick < 69)
            begin
                // A chord on every channel, all ending on the next scan.
                burst = 1'b1;
                for (int ch = 0; ch < mnpt_pkg::CHANNELS_DEF; ch++)
                begin
                    r = random_request(mnpt_pkg::REQ_NOTE_ON);
                    r.chan   = mnpt_pkg::CHAN_W'(ch);
                    r.start  = msg_board.tick;
                    r.length = '0;
                    send_request(r);
                end
                send_request(random_request(mnpt_pkg::REQ_TICK_BEGIN));
                burst = 1'b0;
            end
            else if (pick < 73)
                send_request(random_request(mnpt_pkg::REQ_PLAY));
            else if (pick < 76)
                send_request(random_request(mnpt_pkg::REQ_STOP));
            else if (pick < 81)
            begin
                r = random_request(mnpt_pkg::REQ_SEEK);
                if ($urandom_range(0, 1) != 0)
                    r.seek = msg_board.tick + $urandom_range(0, 4);
                send_request(r);
            end
            else if (pick < 84)
                send_request(random_request(REQ_UNUSED));
            else
                send_request(random_request(mnpt_pkg::REQ_W'($urandom_range(0, 7))));
        end
        push <= 1'b0;

        // Drain, then give a late or extra message time to show up.
        while (msg_board.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (msg_board.mismatches == 0)
            $display("[midi_note_playback_tracker] OK");
        else
            $display("[midi_note_playback_tracker] ERROR");
        $finish;
    end

    // Message words: pop with random waits and an occasional long hold-off.
    initial
    begin : result_sink
        int             wait_cycles;
        int             taken;
        mnpt_pkg::msg_t got;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            wait_cycles = (taken % 100 < 20) ? 0 : $urandom_range(0, 3);
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got.kind    = msg_kind;
            got.channel = out_channel;
            got.key     = out_key;
            got.vel     = out_velocity;
            got.last    = last;
            msg_board.check_message(got);
            taken++;
        end
    end

    // Watchdog well past the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("[midi_note_playback_tracker] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/mnpt_pkg.sv
rtl/core/mnpt_fifo.sv
rtl/core/mnpt_front.sv
rtl/core/mnpt_back.sv
rtl/core/midi_note_playback_tracker.sv
verif/midi_note_playback_tracker_tb.sv
